// ===== src/cfpf_pkg.sv =====
// cfpf_pkg: shared types, constants and the arctangent table of the
// complementary pitch filter core. No dependencies; used by every file in src.

package cfpf_pkg;

   // fixed point set-up
   localparam int AngleW        = 24;  // pitch angle, Q9.14
   localparam int AngleFracBits = 14;
   localparam int TableFrac     = 24;  // arctangent table in degrees, Q.24
   localparam int TableLen      = 24;
   localparam int CordicSteps   = 16;
   localparam int CordicW       = 36;  // rotation vector and angle accumulator
   localparam int CordicPreShift = 16;
   localparam int StepW         = $clog2(TableLen);
   localparam int RoundShift    = TableFrac - AngleFracBits;
   localparam longint HalfTurnQ = 180 * (longint'(1) << TableFrac);
   localparam logic signed [CordicW-1:0] HalfTurn = CordicW'(HalfTurnQ);
   localparam logic signed [CordicW-1:0] RoundHalf = CordicW'(longint'(1) << (RoundShift - 1));

   // gyro increment: floor((m * 2^F + 8000) / 16000) == floor((m * 2^(F-7) + 62) / 125)
   localparam int DivPreShift  = AngleFracBits - 7;
   localparam int DivOffset    = 62;
   localparam int DivDivisor   = 125;
   localparam int DivRemW      = 7;
   localparam int DivNumW      = 48;
   localparam int DivChunk     = 8;
   localparam int DivCycles    = DivNumW / DivChunk;
   localparam int DivCntW      = $clog2(DivCycles);
   localparam int GyroProdW    = 48;  // |gyro| * delta_ms
   localparam int GyroSatBit   = 40;  // products at or above 2^40 saturate the gyro increment
   localparam int IncMagW      = 41;
   localparam int SumW         = 43;
   localparam int DiffW        = 41;
   localparam int BlendW       = 58;
   localparam int FinalW       = 59;

   // shared multiplier
   localparam int MulAW = 22;
   localparam int MulBW = 17;
   localparam int MulPW = MulAW + MulBW;

   // configuration
   localparam int CsrIndexW = 8;
   localparam int CsrDataW  = 16;
   localparam logic [CsrIndexW-1:0] CsrBlendWeight   = 8'd0;
   localparam logic [CsrIndexW-1:0] CsrMagnitudeGate = 8'd1;
   localparam logic [15:0] BlendWeightReset   = 16'd62259;
   localparam logic [14:0] MagnitudeGateReset = 15'd6144;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_G,
      ST_GATE,
      ST_FIRST,
      ST_GYRO_LO,
      ST_GYRO_HI,
      ST_GYRO_SUM,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DIFF,
      ST_BLEND_LO,
      ST_BLEND_HI,
      ST_BLEND_SUM,
      ST_FINISH,
      ST_OUTPUT
   } cfpf_state_type;

   // atan(2^-i) in degrees, Q.24
   function automatic logic [29:0] atan_deg(input logic [StepW-1:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'd754974720;
         5'd1:  v = 30'd445687602;
         5'd2:  v = 30'd235489088;
         5'd3:  v = 30'd119537938;
         5'd4:  v = 30'd60000934;
         5'd5:  v = 30'd30029717;
         5'd6:  v = 30'd15018523;
         5'd7:  v = 30'd7509720;
         5'd8:  v = 30'd3754917;
         5'd9:  v = 30'd1877466;
         5'd10: v = 30'd938734;
         5'd11: v = 30'd469367;
         5'd12: v = 30'd234684;
         5'd13: v = 30'd117342;
         5'd14: v = 30'd58671;
         5'd15: v = 30'd29335;
         5'd16: v = 30'd14668;
         5'd17: v = 30'd7334;
         5'd18: v = 30'd3667;
         5'd19: v = 30'd1833;
         5'd20: v = 30'd917;
         5'd21: v = 30'd458;
         5'd22: v = 30'd229;
         5'd23: v = 30'd115;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/complementary_pitch_filter_core.sv =====
// complementary_pitch_filter_core: gated imu pitch estimate blending the cordic
// accel angle with the integrated gyro rate. Uses cfpf_pkg, cfpf_cordic, cfpf_gyro_div.
//
//   channel  direction  ports                       content
//   req      in         req_tvalid/tready/tdata     one imu sample
//   rsp      out        rsp_tvalid/tready/tdata/tuser  filtered pitch, sample flag
//   csr      in         csr_valid/ready/index/wdata blend weight, magnitude gate
//
// A sample goes through four multiplier passes and the gate decision, then the 16 step
// cordic plus its rounding step, the longer path, with the gyro product and divider
// running beside it, then the difference, two multiplier passes, the sum and the
// clamp for the blend. The first accepted sample takes only the cordic after the
// gate; a rejected one goes from the gate straight to the output. req_tready is
// high only while idle; a result waits in the output register and the next sample
// is taken meanwhile, but the next result waits until that one is transferred.
// Reset is synchronous and needs no clearing pass.

module complementary_pitch_filter_core (
   input  logic                             clock,
   input  logic                             reset,
   // accel_x, accel_y, accel_z, gyro_rate, time_ms from bit 0 up
   input  logic [95:0]                      req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pitch_angle
   output logic [23:0]                      rsp_tdata,
   // sample_used
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfpf_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [cfpf_pkg::CsrDataW-1:0]    csr_wdata
);

   cfpf_pkg::cfpf_state_type state_ff, state_in;

   logic [15:0] blend_weight_ff, blend_weight_in;
   logic [14:0] magnitude_gate_ff, magnitude_gate_in;

   logic signed [cfpf_pkg::AngleW-1:0] angle_ff, angle_in;
   logic                               awaiting_ff, awaiting_in;
   logic [31:0]                        prev_time_ff, prev_time_in;

   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in, gyro_ff, gyro_in;
   logic [31:0]        time_ff, time_in;

   logic signed [cfpf_pkg::MulAW-1:0] mul_a;
   logic signed [cfpf_pkg::MulBW-1:0] mul_b;
   logic signed [cfpf_pkg::MulPW-1:0] prod_ff, prod_in;

   logic [31:0]                          mag_ff, mag_in;
   logic [cfpf_pkg::GyroProdW-1:0]       gprod_ff, gprod_in;
   logic signed [cfpf_pkg::SumW-1:0]     sum_ff, sum_in;
   logic signed [cfpf_pkg::DiffW-1:0]    diff_ff, diff_in;
   logic signed [cfpf_pkg::BlendW-1:0]   blend_ff, blend_in;
   logic                                 used_ff, used_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]                          rsp_data_ff, rsp_data_in;
   logic                                 rsp_used_ff, rsp_used_in;

   logic                                 cordic_start;
   logic                                 cordic_busy;
   logic signed [cfpf_pkg::AngleW-1:0]   cordic_angle;
   logic                                 div_start;
   logic                                 div_busy;
   logic [cfpf_pkg::DivNumW-1:0]         div_num;
   logic [cfpf_pkg::DivNumW-1:0]         div_quo;

   logic [31:0]                          delta_ms;
   logic signed [16:0]                   gyro_abs;
   logic [cfpf_pkg::IncMagW-1:0]         inc_mag;
   logic signed [cfpf_pkg::IncMagW:0]    inc;
   logic signed [cfpf_pkg::SumW:0]       diff_full;
   logic signed [cfpf_pkg::FinalW-1:0]   final_sum;
   logic signed [cfpf_pkg::FinalW-17:0]  final_shr;
   logic                                 final_fits;

   assign delta_ms = time_ff - prev_time_ff;
   assign gyro_abs = gyro_ff[15] ? -17'(gyro_ff) : 17'(gyro_ff);
   assign div_num  = {1'b0, gprod_ff[cfpf_pkg::GyroSatBit-1:0],
                      cfpf_pkg::DivPreShift'(cfpf_pkg::DivOffset)};

   // products at or above 2^40 take the largest increment; any non-zero blend weight then saturates the output
   assign inc_mag = (|gprod_ff[cfpf_pkg::GyroProdW-1:cfpf_pkg::GyroSatBit]) ?
                    '1 : div_quo[cfpf_pkg::IncMagW-1:0];
   assign inc     = gyro_ff[15] ? -signed'({1'b0, inc_mag}) : signed'({1'b0, inc_mag});

   assign diff_full = (cfpf_pkg::SumW+1)'(sum_ff) - (cfpf_pkg::SumW+1)'(cordic_angle);

   assign final_sum = (cfpf_pkg::FinalW'(cordic_angle) <<< 16) + cfpf_pkg::FinalW'(blend_ff)
                      + cfpf_pkg::FinalW'(32768);
   assign final_shr  = final_sum[cfpf_pkg::FinalW-1:16];
   assign final_fits = (&final_shr[cfpf_pkg::FinalW-17:23]) ||
                       !(|final_shr[cfpf_pkg::FinalW-17:23]);

   assign prod_in = mul_a * mul_b;

   cfpf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .y_coord (ay_ff),
      .z_coord (az_ff),
      .busy    (cordic_busy),
      .angle   (cordic_angle)
   );

   cfpf_gyro_div u_gyro_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // configuration writes
   always_comb begin
      blend_weight_in   = blend_weight_ff;
      magnitude_gate_in = magnitude_gate_ff;
      if (csr_valid) begin
         if (csr_index == cfpf_pkg::CsrBlendWeight) begin
            blend_weight_in = csr_wdata;
         end else if (csr_index == cfpf_pkg::CsrMagnitudeGate) begin
            magnitude_gate_in = csr_wdata[14:0];
         end
      end
   end

   // sequencer around the shared multiplier
   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      awaiting_in  = awaiting_ff;
      prev_time_in = prev_time_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      gyro_in      = gyro_ff;
      time_in      = time_ff;
      mag_in       = mag_ff;
      gprod_in     = gprod_ff;
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      blend_in     = blend_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_used_in  = rsp_used_ff;
      mul_a        = '0;
      mul_b        = '0;
      cordic_start = 1'b0;
      div_start    = 1'b0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         cfpf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ax_in    = req_tdata[15:0];
               ay_in    = req_tdata[31:16];
               az_in    = req_tdata[47:32];
               gyro_in  = req_tdata[63:48];
               time_in  = req_tdata[95:64];
               state_in = cfpf_pkg::ST_SQ_X;
            end
         end
         cfpf_pkg::ST_SQ_X: begin
            mul_a    = cfpf_pkg::MulAW'(ax_ff);
            mul_b    = cfpf_pkg::MulBW'(ax_ff);
            state_in = cfpf_pkg::ST_SQ_Y;
         end
         cfpf_pkg::ST_SQ_Y: begin
            mul_a    = cfpf_pkg::MulAW'(ay_ff);
            mul_b    = cfpf_pkg::MulBW'(ay_ff);
            mag_in   = prod_ff[31:0];
            state_in = cfpf_pkg::ST_SQ_Z;
         end
         cfpf_pkg::ST_SQ_Z: begin
            mul_a    = cfpf_pkg::MulAW'(az_ff);
            mul_b    = cfpf_pkg::MulBW'(az_ff);
            mag_in   = mag_ff + prod_ff[31:0];
            state_in = cfpf_pkg::ST_SQ_G;
         end
         cfpf_pkg::ST_SQ_G: begin
            mul_a    = signed'(cfpf_pkg::MulAW'(magnitude_gate_ff));
            mul_b    = signed'(cfpf_pkg::MulBW'(magnitude_gate_ff));
            mag_in   = mag_ff + prod_ff[31:0];
            state_in = cfpf_pkg::ST_GATE;
         end
         cfpf_pkg::ST_GATE: begin
            if (mag_ff < prod_ff[31:0]) begin
               cordic_start = 1'b1;
               used_in      = 1'b1;
               state_in     = awaiting_ff ? cfpf_pkg::ST_FIRST : cfpf_pkg::ST_GYRO_LO;
            end else begin
               // rejected: angle and timestamp held
               used_in  = 1'b0;
               state_in = cfpf_pkg::ST_OUTPUT;
            end
         end
         cfpf_pkg::ST_FIRST: begin
            if (!cordic_busy) begin
               angle_in     = cordic_angle;
               awaiting_in  = 1'b0;
               prev_time_in = time_ff;
               state_in     = cfpf_pkg::ST_OUTPUT;
            end
         end
         cfpf_pkg::ST_GYRO_LO: begin
            mul_a    = cfpf_pkg::MulAW'(gyro_abs);
            mul_b    = signed'({1'b0, delta_ms[15:0]});
            state_in = cfpf_pkg::ST_GYRO_HI;
         end
         cfpf_pkg::ST_GYRO_HI: begin
            mul_a    = cfpf_pkg::MulAW'(gyro_abs);
            mul_b    = signed'({1'b0, delta_ms[31:16]});
            gprod_in = cfpf_pkg::GyroProdW'(prod_ff[31:0]);
            state_in = cfpf_pkg::ST_GYRO_SUM;
         end
         cfpf_pkg::ST_GYRO_SUM: begin
            gprod_in = gprod_ff + (cfpf_pkg::GyroProdW'(prod_ff[31:0]) << 16);
            state_in = cfpf_pkg::ST_DIV_GO;
         end
         cfpf_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = cfpf_pkg::ST_DIV_WAIT;
         end
         cfpf_pkg::ST_DIV_WAIT: begin
            if (!div_busy && !cordic_busy) begin
               sum_in   = cfpf_pkg::SumW'(angle_ff) + cfpf_pkg::SumW'(inc);
               state_in = cfpf_pkg::ST_DIFF;
            end
         end
         cfpf_pkg::ST_DIFF: begin
            // clamp keeps the sign; with a non-zero blend weight any clamped value saturates the output
            if ((&diff_full[cfpf_pkg::SumW:cfpf_pkg::DiffW-1]) ||
                !(|diff_full[cfpf_pkg::SumW:cfpf_pkg::DiffW-1])) begin
               diff_in = diff_full[cfpf_pkg::DiffW-1:0];
            end else if (diff_full[cfpf_pkg::SumW]) begin
               diff_in = {1'b1, {(cfpf_pkg::DiffW-1){1'b0}}};
            end else begin
               diff_in = {1'b0, {(cfpf_pkg::DiffW-1){1'b1}}};
            end
            state_in = cfpf_pkg::ST_BLEND_LO;
         end
         cfpf_pkg::ST_BLEND_LO: begin
            mul_a    = signed'({1'b0, diff_ff[20:0]});
            mul_b    = signed'({1'b0, blend_weight_ff});
            state_in = cfpf_pkg::ST_BLEND_HI;
         end
         cfpf_pkg::ST_BLEND_HI: begin
            mul_a    = cfpf_pkg::MulAW'(signed'(diff_ff[cfpf_pkg::DiffW-1:21]));
            mul_b    = signed'({1'b0, blend_weight_ff});
            blend_in = cfpf_pkg::BlendW'(prod_ff);
            state_in = cfpf_pkg::ST_BLEND_SUM;
         end
         cfpf_pkg::ST_BLEND_SUM: begin
            blend_in = blend_ff + (cfpf_pkg::BlendW'(prod_ff) <<< 21);
            state_in = cfpf_pkg::ST_FINISH;
         end
         cfpf_pkg::ST_FINISH: begin
            if (final_fits) begin
               angle_in = final_shr[cfpf_pkg::AngleW-1:0];
            end else if (final_shr[cfpf_pkg::FinalW-17]) begin
               angle_in = {1'b1, {(cfpf_pkg::AngleW-1){1'b0}}};
            end else begin
               angle_in = {1'b0, {(cfpf_pkg::AngleW-1){1'b1}}};
            end
            prev_time_in = time_ff;
            state_in     = cfpf_pkg::ST_OUTPUT;
         end
         cfpf_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = angle_ff;
               rsp_used_in  = used_ff;
               state_in     = cfpf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfpf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= cfpf_pkg::ST_IDLE;
         blend_weight_ff   <= cfpf_pkg::BlendWeightReset;
         magnitude_gate_ff <= cfpf_pkg::MagnitudeGateReset;
         angle_ff          <= '0;
         awaiting_ff       <= 1'b1;
         prev_time_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         blend_weight_ff   <= blend_weight_in;
         magnitude_gate_ff <= magnitude_gate_in;
         angle_ff          <= angle_in;
         awaiting_ff       <= awaiting_in;
         prev_time_ff      <= prev_time_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      gyro_ff     <= gyro_in;
      time_ff     <= time_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
      gprod_ff    <= gprod_in;
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      blend_ff    <= blend_in;
      used_ff     <= used_in;
      rsp_data_ff <= rsp_data_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_used_ff;

endmodule

// ===== src/cfpf_cordic.sv =====
// cfpf_cordic: iterative vectoring cordic giving atan2(y, z) in degrees, Q9.14.
// One rotation per cycle on a shared add/shift datapath; depends on cfpf_pkg.

module cfpf_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [15:0]                 y_coord,
   input  logic signed [15:0]                 z_coord,
   output logic                               busy,
   output logic signed [cfpf_pkg::AngleW-1:0] angle
);

   logic signed [cfpf_pkg::CordicW-1:0] x_ff, x_in;
   logic signed [cfpf_pkg::CordicW-1:0] y_ff, y_in;
   logic signed [cfpf_pkg::CordicW-1:0] acc_ff, acc_in;
   logic [cfpf_pkg::StepW-1:0]          step_ff, step_in;
   logic                                busy_ff, busy_in;
   logic signed [cfpf_pkg::AngleW-1:0]  angle_ff, angle_in;

   logic                                neg_z;
   logic signed [16:0]                  z_abs;
   logic signed [16:0]                  y_rot;
   logic signed [cfpf_pkg::CordicW-1:0] x_shift;
   logic signed [cfpf_pkg::CordicW-1:0] y_shift;
   logic signed [cfpf_pkg::CordicW-1:0] atan_step;
   logic signed [cfpf_pkg::CordicW-1:0] rounded;

   assign neg_z     = z_coord[15];
   assign z_abs     = neg_z ? -17'(z_coord) : 17'(z_coord);
   assign y_rot     = neg_z ? -17'(y_coord) : 17'(y_coord);
   assign x_shift   = x_ff >>> step_ff;
   assign y_shift   = y_ff >>> step_ff;
   assign atan_step = signed'(cfpf_pkg::CordicW'(cfpf_pkg::atan_deg(step_ff)));
   assign rounded   = acc_ff + cfpf_pkg::RoundHalf;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      angle_in = angle_ff;
      if (start) begin
         if (y_coord == 16'sd0 && z_coord == 16'sd0) begin
            // zero vector reads as level
            angle_in = '0;
            busy_in  = 1'b0;
         end else begin
            x_in    = cfpf_pkg::CordicW'(z_abs) <<< cfpf_pkg::CordicPreShift;
            y_in    = cfpf_pkg::CordicW'(y_rot) <<< cfpf_pkg::CordicPreShift;
            // negative z: pre-rotate by half a turn towards the sign of y
            if (!neg_z) begin
               acc_in = '0;
            end else if (y_coord[15]) begin
               acc_in = -cfpf_pkg::HalfTurn;
            end else begin
               acc_in = cfpf_pkg::HalfTurn;
            end
            step_in = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (step_ff == cfpf_pkg::StepW'(cfpf_pkg::CordicSteps)) begin
            angle_in = rounded[cfpf_pkg::RoundShift +: cfpf_pkg::AngleW];
            busy_in  = 1'b0;
         end else begin
            if (!y_ff[cfpf_pkg::CordicW-1]) begin
               x_in   = x_ff + y_shift;
               y_in   = y_ff - x_shift;
               acc_in = acc_ff + atan_step;
            end else begin
               x_in   = x_ff - y_shift;
               y_in   = y_ff + x_shift;
               acc_in = acc_ff - atan_step;
            end
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         angle_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         angle_ff <= angle_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

   assign busy  = busy_ff;
   assign angle = angle_ff;

endmodule

// ===== src/cfpf_gyro_div.sv =====
// cfpf_gyro_div: divides the scaled gyro product by 125, eight quotient bits
// per cycle with a narrow remainder. Depends on cfpf_pkg.

module cfpf_gyro_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cfpf_pkg::DivNumW-1:0] dividend,
   output logic                         busy,
   output logic [cfpf_pkg::DivNumW-1:0] quotient
);

   logic [cfpf_pkg::DivNumW-1:0]   num_ff, num_in;
   logic [cfpf_pkg::DivNumW-1:0]   quo_ff, quo_in;
   logic [cfpf_pkg::DivRemW-1:0]   rem_ff, rem_in;
   logic [cfpf_pkg::DivCntW-1:0]   cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;

   logic [cfpf_pkg::DivRemW-1:0]   rem_step;
   logic [cfpf_pkg::DivRemW:0]     trial;
   logic [cfpf_pkg::DivChunk-1:0]  q_chunk;

   // restoring steps over the top bits of the shifting numerator
   always_comb begin
      rem_step = rem_ff;
      trial    = '0;
      q_chunk  = '0;
      for (int k = 0; k < cfpf_pkg::DivChunk; k++) begin
         trial = {rem_step, num_ff[cfpf_pkg::DivNumW-1-k]};
         if (trial >= (cfpf_pkg::DivRemW+1)'(cfpf_pkg::DivDivisor)) begin
            q_chunk[cfpf_pkg::DivChunk-1-k] = 1'b1;
            rem_step = cfpf_pkg::DivRemW'(trial - (cfpf_pkg::DivRemW+1)'(cfpf_pkg::DivDivisor));
         end else begin
            rem_step = trial[cfpf_pkg::DivRemW-1:0];
         end
      end
   end

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << cfpf_pkg::DivChunk;
         quo_in = {quo_ff[cfpf_pkg::DivNumW-cfpf_pkg::DivChunk-1:0], q_chunk};
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cfpf_pkg::DivCntW'(cfpf_pkg::DivCycles - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for complementary_pitch_filter_core, streaming imu samples
// in and checking every filtered pitch result against a cycle-free model of the filter.
// Depends on cfpf_pkg (register indexes, reset values) and the core in src.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   // packed so that accel_x lands in the low bits of req_tdata
   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [15:0] gyro_rate;
      logic signed [15:0] accel_z;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_x;
   } sample_type;

   typedef struct {
      logic signed [23:0] angle;
      logic               used;
   } pitch_type;

   localparam int     RotSteps  = 16;
   localparam int     FracBits  = 14;
   localparam int     AtanFrac  = 24;
   localparam longint AngleMax  = 8388607;
   localparam longint AngleMin  = -8388608;
   localparam longint SumClip   = longint'(1) << 46;
   localparam longint AtanQ24 [0:15] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335
   };

   logic        clock;
   logic        reset = 1'b1;
   logic [95:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [cfpf_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [cfpf_pkg::CsrDataW-1:0]  csr_wdata = '0;

   // filter state and register copies
   logic signed [23:0] angle_q = '0;
   logic               awaiting_first = 1'b1;
   logic [31:0]        prev_time = '0;
   logic [15:0]        alpha_q = cfpf_pkg::BlendWeightReset;
   logic [14:0]        gate_q  = cfpf_pkg::MagnitudeGateReset;

   sample_type  pending_samples[$];
   pitch_type   expected_pitch[$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          error_count = 0;
   int          samples_sent = 0;
   int          results_seen = 0;
   int          gated_in = 0;
   logic [31:0] stim_time = 32'd1000;

   complementary_pitch_filter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // accel pitch atan2(y, z) in degrees, rounded to FracBits
   function automatic longint accel_pitch(longint y, longint z);
      longint x, acc, t;
      int     i;
      if (y == 0 && z == 0)
         return 0;
      acc = 0;
      if (z < 0) begin
         // pre-rotate by half a turn into the right half plane
         acc = (y >= 0) ? longint'(180) * (longint'(1) << AtanFrac)
                        : -(longint'(180) * (longint'(1) << AtanFrac));
         z = -z;
         y = -y;
      end
      x = z * 65536;
      y = y * 65536;
      for (i = 0; i < RotSteps; i++) begin
         t = x;
         if (y >= 0) begin
            x += y >>> i;
            y -= t >>> i;
            acc += AtanQ24[i];
         end else begin
            x -= y >>> i;
            y += t >>> i;
            acc -= AtanQ24[i];
         end
      end
      acc += longint'(1) << (AtanFrac - FracBits - 1);
      return acc >>> (AtanFrac - FracBits);
   endfunction

   // gyro * dt in degrees, magnitude rounded half away from zero
   function automatic longint gyro_step(longint g, logic [31:0] dms);
      longint  abs_g;
      u64_type m, q, r, mag;
      abs_g = (g < 0) ? -g : g;
      m = u64_type'(abs_g) * u64_type'(dms);
      q = m / 16000;
      r = m % 16000;
      mag = (q << FracBits) + ((r << FracBits) + 8000) / 16000;
      return (g < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic pitch_type filter_sample(sample_type s);
      longint ax, ay, az, g, mag2, gate2, acc, sum, res;
      pitch_type p;
      ax = s.accel_x;
      ay = s.accel_y;
      az = s.accel_z;
      g = s.gyro_rate;
      mag2 = ax * ax + ay * ay + az * az;
      gate2 = longint'(gate_q) * longint'(gate_q);
      p.used = 1'b0;
      if (mag2 < gate2) begin
         p.used = 1'b1;
         acc = accel_pitch(ay, az);
         if (awaiting_first) begin
            res = acc;
            awaiting_first = 1'b0;
         end else begin
            sum = angle_q;
            sum += gyro_step(g, s.time_ms - prev_time);
            if (sum > SumClip)
               sum = SumClip;
            if (sum < -SumClip)
               sum = -SumClip;
            res = sum * longint'(alpha_q) + acc * (65536 - longint'(alpha_q)) + 32768;
            res = res >>> 16;
         end
         prev_time = s.time_ms;
         if (res > AngleMax)
            res = AngleMax;
         if (res < AngleMin)
            res = AngleMin;
         angle_q = res[23:0];
      end
      p.angle = angle_q;
      return p;
   endfunction

   task automatic note_mismatch(string what, longint got, longint want);
      $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic signed [15:0] signed_within(int lim);
      int v;
      v = int'($urandom_range(2 * lim)) - lim;
      return 16'(v);
   endfunction

   task automatic queue_item(int ax, int ay, int az, int g, logic [31:0] t);
      sample_type s;
      s.accel_x = 16'(ax);
      s.accel_y = 16'(ay);
      s.accel_z = 16'(az);
      s.gyro_rate = 16'(g);
      s.time_ms = t;
      pending_samples.push_back(s);
   endtask

   task automatic queue_random(int count);
      int kind, lim, g;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         g = ($urandom_range(1) == 1) ? int'(signed_within(2000)) : int'($urandom_range(65535));
         if (kind < 80) begin
            // mostly inside the gate, some straddling it
            lim = (kind < 70) ? int'(gate_q) / 2 : int'(gate_q) * 3 / 5;
            stim_time += $urandom_range(1, 40);
            queue_item(signed_within(lim), signed_within(lim), signed_within(lim), g,
                       stim_time);
         end else begin
            if (kind < 95)
               stim_time = $urandom;
            else
               stim_time += $urandom;
            queue_item($urandom_range(65535), $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(65535), stim_time);
         end
      end
   endtask

   task automatic write_csr(logic [cfpf_pkg::CsrIndexW-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == cfpf_pkg::CsrBlendWeight)
         alpha_q = val;
      else
         gate_q = val[14:0];
   endtask

   task automatic drain;
      while (pending_samples.size() != 0 || req_tvalid || expected_pitch.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_pitch.push_back(filter_sample(sample_type'(req_tdata)));
            samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_samples.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      pitch_type want;
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser)
            gated_in++;
         if (expected_pitch.size() == 0) begin
            note_mismatch("result with nothing pending, pitch", $signed(rsp_tdata), 0);
         end else begin
            want = expected_pitch.pop_front();
            if ($signed(rsp_tdata) != want.angle)
               note_mismatch("pitch_angle", $signed(rsp_tdata), want.angle);
            if (rsp_tuser !== want.used)
               note_mismatch("sample_used", rsp_tuser, want.used);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still pending", expected_pitch.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // reset settings, no idling: zero vector, quadrants, gate edge, wrap, saturation
      queue_item(0, 0, 0, 0, 100);
      queue_item(0, 0, 4096, 160, 110);
      queue_item(0, 4096, 0, -160, 120);
      queue_item(0, 0, -4096, 0, 130);
      queue_item(0, -2000, -3000, 16, 140);
      queue_item(0, 3000, -3000, -16, 150);
      queue_item(32767, 32767, 32767, 32767, 160);
      queue_item(-32768, -32768, -32768, -32768, 170);
      queue_item(6143, 0, 0, 0, 180);
      queue_item(6144, 0, 0, 0, 190);
      queue_item(0, -6143, 0, 0, 200);
      queue_item(0, 2000, 2000, 32767, 32'hFFFF_FFF0);
      queue_item(0, 2000, 2000, -32768, 32'h0000_0005);
      queue_item(0, 2000, -2000, -32768, 32'h7FFF_FFFF);
      queue_item(0, 0, 0, 0, 32'h7FFF_FFFF);
      queue_item(-6143, 0, 0, 1, 32'hFFFF_FFFF);
      queue_item(0, 0, 1, -1, 32'h0000_0000);
      queue_item(0, -1, 0, 2, 3);
      queue_item(0, 1, -1, 32767, 9);
      queue_item(100, -100, -1, -32768, 12);
      queue_item(-4000, 3000, 2000, 800, 40);
      queue_random(80);
      drain();

      // pure accel path, widest gate, sender idling
      write_csr(cfpf_pkg::CsrBlendWeight, 16'd0);
      write_csr(cfpf_pkg::CsrMagnitudeGate, 16'd32767);
      send_idle_pct = 78;
      queue_random(110);
      drain();

      // nearly pure gyro path, default gate, receiver stalling
      write_csr(cfpf_pkg::CsrBlendWeight, 16'd65535);
      write_csr(cfpf_pkg::CsrMagnitudeGate, 16'd6144);
      send_idle_pct = 0;
      recv_stall_pct = 78;
      queue_random(110);
      drain();

      // closed gate: everything held
      write_csr(cfpf_pkg::CsrBlendWeight, 16'd30000);
      write_csr(cfpf_pkg::CsrMagnitudeGate, 16'd0);
      send_idle_pct = 11;
      recv_stall_pct = 11;
      queue_random(40);
      drain();

      write_csr(cfpf_pkg::CsrBlendWeight, 16'd62259);
      write_csr(cfpf_pkg::CsrMagnitudeGate, 16'd4096);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random(110);
      drain();

      write_csr(cfpf_pkg::CsrBlendWeight, 16'($urandom_range(65535)));
      write_csr(cfpf_pkg::CsrMagnitudeGate, 16'($urandom_range(32767, 2000)));
      send_idle_pct = 11;
      recv_stall_pct = 11;
      queue_random(100);
      drain();

      $display("%0d samples sent, %0d results checked, %0d passed the gate",
               samples_sent, results_seen, gated_in);
      $display("blend weight and gate swept through both extremes under four pacing modes");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
